[sv/ising_metropolis_spin_update_unit_macros.svh]
// ----------------------------------------------------------------------------
// ising metropolis spin update unit - assertion macros
// shared concurrent assertion forms, clocked on clk and disabled in reset
// ----------------------------------------------------------------------------
`ifndef ISING_METROPOLIS_SPIN_UPDATE_UNIT_MACROS_SVH
`define ISING_METROPOLIS_SPIN_UPDATE_UNIT_MACROS_SVH

// condition and consequence in the same cycle
`define ISMU_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// consequence in the cycle after the condition
`define ISMU_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[sv/ismu_pkg.sv]
// ----------------------------------------------------------------------------
// ismu_pkg
// lattice geometry, field types, register codes and controller states
// ----------------------------------------------------------------------------
package ismu_pkg;

	// lattice geometry, both sides powers of two
	localparam int LATTICE_ROWS    = 128;
	localparam int LATTICE_COLUMNS = 128;
	localparam int SITE_COUNT      = LATTICE_ROWS * LATTICE_COLUMNS;
	localparam int ROW_W           = $clog2(LATTICE_ROWS);
	localparam int COL_W           = $clog2(LATTICE_COLUMNS);

	// field widths
	localparam int INDEX_W  = 7;
	localparam int FRAC_W   = 32;
	localparam int DE_W     = 5;
	localparam int ENERGY_W = 17;
	localparam int MAG_W    = 16;
	localparam int CFG_IDX_W = 2;

	typedef logic [INDEX_W-1:0]          site_index_t;
	typedef logic [FRAC_W-1:0]           frac_t;
	typedef logic signed [DE_W-1:0]      de_t;
	typedef logic signed [ENERGY_W-1:0]  energy_t;
	typedef logic signed [MAG_W-1:0]     mag_t;
	typedef logic [CFG_IDX_W-1:0]        cfg_idx_t;
	typedef logic [ROW_W-1:0]            row_idx_t;
	typedef logic [COL_W-1:0]            col_idx_t;
	typedef logic [LATTICE_COLUMNS-1:0]  row_t;

	// configuration register indexes
	localparam cfg_idx_t CFG_THRESH_FOUR  = cfg_idx_t'(0);
	localparam cfg_idx_t CFG_THRESH_EIGHT = cfg_idx_t'(1);

	localparam frac_t THRESH_FOUR_RESET  = frac_t'(581260605);
	localparam frac_t THRESH_EIGHT_RESET = frac_t'(78665071);

	localparam energy_t ENERGY_RESET = energy_t'(-2 * SITE_COUNT);
	localparam mag_t    MAG_RESET    = mag_t'(SITE_COUNT);
	localparam mag_t    MAG_STEP     = mag_t'(2);

	localparam de_t DE_ZERO = de_t'(0);
	localparam de_t DE_FOUR = de_t'(4);

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_RD_DN,
		ST_RD_UP,
		ST_EVAL
	} state_t;

endpackage

[sv/ismu_ifs.sv]
// ----------------------------------------------------------------------------
// ismu channel interfaces
// proposal, result and configuration write channels with valid/ready
// ----------------------------------------------------------------------------
interface ismu_proposal_if;
	logic                 valid;
	logic                 ready;
	ismu_pkg::site_index_t row_index;
	ismu_pkg::site_index_t column_index;
	ismu_pkg::frac_t      random_fraction;

	modport source (output valid, output row_index, output column_index,
		output random_fraction, input ready);
	modport sink (input valid, input row_index, input column_index,
		input random_fraction, output ready);
endinterface

interface ismu_result_if;
	logic              valid;
	logic              ready;
	logic              accepted;
	ismu_pkg::de_t     energy_change;
	ismu_pkg::energy_t total_energy;
	ismu_pkg::mag_t    total_magnetization;

	modport source (output valid, output accepted, output energy_change,
		output total_energy, output total_magnetization, input ready);
	modport sink (input valid, input accepted, input energy_change,
		input total_energy, input total_magnetization, output ready);
endinterface

interface ismu_cfg_if;
	logic               valid;
	logic               ready;
	ismu_pkg::cfg_idx_t index;
	ismu_pkg::frac_t    data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

[sv/ismu_ram.sv]
// ----------------------------------------------------------------------------
// ismu_ram
// simple dual-port ram, one write and one read port, registered read data
// ----------------------------------------------------------------------------
module ismu_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

[sv/ising_metropolis_spin_update_unit.sv]
// ----------------------------------------------------------------------------
// ising_metropolis_spin_update_unit
// Metropolis single-spin-flip update on a periodic square Ising lattice. The
// lattice lives in a row-wide ram (one row of spins per word) that is filled
// with up spins by a clearing pass over all LATTICE_ROWS rows after reset; the
// proposal channel is held off during that pass, configuration writes are
// taken throughout. For each proposed site the three rows around it are read
// one after another through the single read port; the eval state then
// decides, writes the row back and loads the result register, which lets
// the next proposal be accepted while a word still waits. Only a full result
// register that is not being taken stalls the decide state. Row and column
// indexes are reduced modulo the lattice size; totals wrap at their widths.
// ----------------------------------------------------------------------------
module ising_metropolis_spin_update_unit (
	input  logic       clk,
	input  logic       arst_n,
	ismu_proposal_if.sink proposal,
	ismu_result_if.source result,
	ismu_cfg_if.sink      cfg
);

	ismu_pkg::state_t    state_q, state_d;
	ismu_pkg::row_idx_t  clr_cnt_q;
	ismu_pkg::row_idx_t  row_q;
	ismu_pkg::col_idx_t  col_q;
	ismu_pkg::frac_t     rnd_q;
	ismu_pkg::row_t      center_row_q;
	logic                dn_bit_q;
	ismu_pkg::energy_t   energy_q;
	ismu_pkg::mag_t      mag_q;
	ismu_pkg::frac_t     thresh_four_q;
	ismu_pkg::frac_t     thresh_eight_q;

	logic                out_valid_q;
	logic                out_accepted_q;
	ismu_pkg::de_t       out_de_q;
	ismu_pkg::energy_t   out_energy_q;
	ismu_pkg::mag_t      out_mag_q;

	ismu_pkg::row_idx_t  in_row;
	ismu_pkg::col_idx_t  in_col;
	ismu_pkg::row_idx_t  row_up, row_dn;
	ismu_pkg::col_idx_t  col_up, col_dn;

	logic                ram_we;
	ismu_pkg::row_idx_t  ram_waddr, ram_raddr;
	ismu_pkg::row_t      ram_wdata, ram_rdata;

	logic                take_in;
	logic                capture_center;
	logic                capture_dn;
	logic                eval_go;
	logic                spin;
	logic [2:0]          n_up;
	logic signed [5:0]   de_up;
	ismu_pkg::de_t       de;
	logic                acc;

	ismu_ram #(
		.WIDTH (ismu_pkg::LATTICE_COLUMNS),
		.DEPTH (ismu_pkg::LATTICE_ROWS)
	) u_lattice (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	assign in_row = ismu_pkg::row_idx_t'(proposal.row_index % ismu_pkg::LATTICE_ROWS);
	assign in_col = ismu_pkg::col_idx_t'(proposal.column_index % ismu_pkg::LATTICE_COLUMNS);

	// periodic neighbors
	assign row_up = (row_q == ismu_pkg::row_idx_t'(ismu_pkg::LATTICE_ROWS - 1))
		? '0 : row_q + 1'b1;
	assign row_dn = (row_q == '0)
		? ismu_pkg::row_idx_t'(ismu_pkg::LATTICE_ROWS - 1) : row_q - 1'b1;
	assign col_up = (col_q == ismu_pkg::col_idx_t'(ismu_pkg::LATTICE_COLUMNS - 1))
		? '0 : col_q + 1'b1;
	assign col_dn = (col_q == '0)
		? ismu_pkg::col_idx_t'(ismu_pkg::LATTICE_COLUMNS - 1) : col_q - 1'b1;

	// decide: ram_rdata holds the row above during the eval state
	assign spin  = center_row_q[col_q];
	assign n_up  = 3'(ram_rdata[col_q]) + 3'(dn_bit_q)
		+ 3'(center_row_q[col_up]) + 3'(center_row_q[col_dn]);
	assign de_up = $signed({1'b0, n_up, 2'b00}) - 6'sd8;
	assign de    = ismu_pkg::de_t'(spin ? de_up : -de_up);

	always_comb begin
		if (de <= ismu_pkg::DE_ZERO) begin
			acc = 1'b1;
		end else if (de == ismu_pkg::DE_FOUR) begin
			acc = rnd_q < thresh_four_q;
		end else begin
			acc = rnd_q < thresh_eight_q;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ismu_pkg::ST_CLEAR: begin
				if (clr_cnt_q == ismu_pkg::row_idx_t'(ismu_pkg::LATTICE_ROWS - 1)) begin
					state_d = ismu_pkg::ST_IDLE;
				end
			end
			ismu_pkg::ST_IDLE: begin
				if (proposal.valid) begin
					state_d = ismu_pkg::ST_RD_DN;
				end
			end
			ismu_pkg::ST_RD_DN: state_d = ismu_pkg::ST_RD_UP;
			ismu_pkg::ST_RD_UP: state_d = ismu_pkg::ST_EVAL;
			ismu_pkg::ST_EVAL: begin
				if (!out_valid_q || result.ready) begin
					state_d = ismu_pkg::ST_IDLE;
				end
			end
			default: state_d = ismu_pkg::ST_CLEAR;
		endcase
	end

	// outputs of the controller
	always_comb begin
		proposal.ready = 1'b0;
		capture_center = 1'b0;
		capture_dn     = 1'b0;
		eval_go        = 1'b0;
		ram_we         = 1'b0;
		ram_waddr      = row_q;
		ram_wdata      = center_row_q ^ (ismu_pkg::row_t'(1) << col_q);
		ram_raddr      = in_row;
		unique case (state_q)
			ismu_pkg::ST_CLEAR: begin
				ram_we    = 1'b1;
				ram_waddr = clr_cnt_q;
				ram_wdata = '1;
			end
			ismu_pkg::ST_IDLE: begin
				proposal.ready = 1'b1;
			end
			ismu_pkg::ST_RD_DN: begin
				capture_center = 1'b1;
				ram_raddr      = row_dn;
			end
			ismu_pkg::ST_RD_UP: begin
				capture_dn = 1'b1;
				ram_raddr  = row_up;
			end
			ismu_pkg::ST_EVAL: begin
				// hold the address so the row above stays on the read port
				ram_raddr = row_up;
				eval_go   = !out_valid_q || result.ready;
				ram_we    = eval_go && acc;
			end
			default: ;
		endcase
	end

	assign take_in = proposal.valid && proposal.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ismu_pkg::ST_CLEAR;
			clr_cnt_q <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ismu_pkg::ST_CLEAR) begin
				clr_cnt_q <= clr_cnt_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take_in) begin
			row_q <= in_row;
			col_q <= in_col;
			rnd_q <= proposal.random_fraction;
		end
		if (capture_center) begin
			center_row_q <= ram_rdata;
		end
		if (capture_dn) begin
			dn_bit_q <= ram_rdata[col_q];
		end
	end

	// totals and thresholds
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			energy_q       <= ismu_pkg::ENERGY_RESET;
			mag_q          <= ismu_pkg::MAG_RESET;
			thresh_four_q  <= ismu_pkg::THRESH_FOUR_RESET;
			thresh_eight_q <= ismu_pkg::THRESH_EIGHT_RESET;
		end else begin
			if (eval_go && acc) begin
				energy_q <= energy_q + ismu_pkg::energy_t'(de);
				mag_q    <= spin ? mag_q - ismu_pkg::MAG_STEP : mag_q + ismu_pkg::MAG_STEP;
			end
			if (cfg.valid) begin
				unique case (cfg.index)
					ismu_pkg::CFG_THRESH_FOUR:  thresh_four_q  <= cfg.data;
					ismu_pkg::CFG_THRESH_EIGHT: thresh_eight_q <= cfg.data;
					default: ;
				endcase
			end
		end
	end

	assign cfg.ready = 1'b1;

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (eval_go) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (eval_go) begin
			out_accepted_q <= acc;
			out_de_q       <= de;
			out_energy_q   <= acc ? energy_q + ismu_pkg::energy_t'(de) : energy_q;
			out_mag_q      <= !acc ? mag_q
				: (spin ? mag_q - ismu_pkg::MAG_STEP : mag_q + ismu_pkg::MAG_STEP);
		end
	end

	assign result.valid               = out_valid_q;
	assign result.accepted            = out_accepted_q;
	assign result.energy_change       = out_de_q;
	assign result.total_energy        = out_energy_q;
	assign result.total_magnetization = out_mag_q;

endmodule

[sv/ismu_checker.sv]
// ----------------------------------------------------------------------------
// ismu_checker
// port-level checks on the result channel of the spin update unit
// ----------------------------------------------------------------------------
`include "ising_metropolis_spin_update_unit_macros.svh"

module ismu_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              result_valid,
	input logic              result_ready,
	input logic              accepted,
	input ismu_pkg::de_t     energy_change,
	input ismu_pkg::energy_t total_energy,
	input ismu_pkg::mag_t    total_magnetization
);

	// flip cost is always a multiple of four within plus or minus eight
	`ISMU_ASSERT_SAME(a_de_legal, result_valid, energy_change == -5'sd8 || energy_change == -5'sd4 || energy_change == 5'sd0 || energy_change == 5'sd4 || energy_change == 5'sd8, "energy change outside the five legal values")

	// a flip that lowers or keeps the energy is never rejected
	`ISMU_ASSERT_SAME(a_downhill_accepted, result_valid && energy_change <= 5'sd0, accepted, "non-positive energy change was rejected")

	// energy moves in steps of four from a multiple of four
	`ISMU_ASSERT_SAME(a_energy_mod4, result_valid, total_energy[1:0] == 2'b00, "total energy not a multiple of four")

	// even site count keeps the spin sum even
	`ISMU_ASSERT_SAME(a_mag_even, result_valid, !total_magnetization[0], "odd total magnetization")

	// a stalled word stays put
	`ISMU_ASSERT_NEXT(a_result_hold, result_valid && !result_ready, result_valid && $stable(accepted) && $stable(energy_change) && $stable(total_energy) && $stable(total_magnetization), "result word changed while stalled")

endmodule

bind ising_metropolis_spin_update_unit ismu_checker u_ismu_checker (
	.clk                 (clk),
	.arst_n              (arst_n),
	.result_valid        (result.valid),
	.result_ready        (result.ready),
	.accepted            (result.accepted),
	.energy_change       (result.energy_change),
	.total_energy        (result.total_energy),
	.total_magnetization (result.total_magnetization)
);

[verif/ising_metropolis_spin_update_unit_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ising_metropolis_spin_update_unit_test
// Drives site proposals into the spin update unit and checks every result
// word against a software copy of the lattice, the two running totals and
// the acceptance thresholds. Directed proposals hit the lattice corners, all
// five energy changes and the strict threshold compare; random phases then
// work small windows of the lattice under several threshold settings, with
// random idling on both channels and one long receiver hold-off.
// ----------------------------------------------------------------------------
module ising_metropolis_spin_update_unit_test;
	import ismu_pkg::*;

	localparam int       SETTLE_CYCLES   = 20;
	localparam int       LONG_HOLD       = 100;
	localparam int       PHASE_COUNT     = 6;
	localparam int       PHASE_ITEMS     = 200;
	localparam frac_t    FRAC_MAX        = 32'hFFFF_FFFF;
	localparam cfg_idx_t CFG_SPARE_TWO   = cfg_idx_t'(2);
	localparam cfg_idx_t CFG_SPARE_THREE = cfg_idx_t'(3);

	typedef struct packed {
		logic    accepted;
		de_t     energy_change;
		energy_t total_energy;
		mag_t    total_magnetization;
	} flip_outcome_t;

	class spin_flip_scoreboard;
		bit            spin_up [LATTICE_ROWS][LATTICE_COLUMNS];
		energy_t       energy_sum;
		mag_t          mag_sum;
		frac_t         thresh_four;
		frac_t         thresh_eight;
		flip_outcome_t outcome_q[$];
		int            errors;
		int            proposals;
		int            flips;
		int            reg_writes;
		int            de_hits[5];

		function new();
			foreach (spin_up[r, c]) spin_up[r][c] = 1'b1;
			energy_sum   = energy_t'(-2 * LATTICE_ROWS * LATTICE_COLUMNS);
			mag_sum      = mag_t'(LATTICE_ROWS * LATTICE_COLUMNS);
			thresh_four  = THRESH_FOUR_RESET;
			thresh_eight = THRESH_EIGHT_RESET;
			errors       = 0;
			proposals    = 0;
			flips        = 0;
			reg_writes   = 0;
			foreach (de_hits[i]) de_hits[i] = 0;
		endfunction

		function int spin_of(int r, int c);
			return spin_up[r][c] ? 1 : -1;
		endfunction

		function void apply_register(cfg_idx_t idx, frac_t value);
			reg_writes++;
			case (idx)
				CFG_THRESH_FOUR:  thresh_four = value;
				CFG_THRESH_EIGHT: thresh_eight = value;
				default: ;
			endcase
		endfunction

		// works out the word that this proposal must produce
		function void note_proposal(site_index_t row, site_index_t col, frac_t frac);
			int            r, c, own, nsum, de;
			bit            acc;
			flip_outcome_t o;
			r    = int'(row) % LATTICE_ROWS;
			c    = int'(col) % LATTICE_COLUMNS;
			own  = spin_of(r, c);
			nsum = spin_of((r + 1) % LATTICE_ROWS, c)
				+ spin_of((r + LATTICE_ROWS - 1) % LATTICE_ROWS, c)
				+ spin_of(r, (c + 1) % LATTICE_COLUMNS)
				+ spin_of(r, (c + LATTICE_COLUMNS - 1) % LATTICE_COLUMNS);
			de   = 2 * own * nsum;
			if (de <= 0)
				acc = 1'b1;
			else if (de == 4)
				acc = frac < thresh_four;
			else
				acc = frac < thresh_eight;
			if (acc) begin
				spin_up[r][c] = !spin_up[r][c];
				energy_sum    = energy_sum + energy_t'(de);
				mag_sum       = mag_sum - mag_t'(2 * own);
				flips++;
			end
			proposals++;
			de_hits[(de + 8) / 4]++;
			o.accepted            = acc;
			o.energy_change       = de_t'(de);
			o.total_energy        = energy_sum;
			o.total_magnetization = mag_sum;
			outcome_q.push_back(o);
		endfunction

		function void report(string field, int expv, int actv);
			errors++;
			$display("%0t: %s mismatch, expected %0d, actual %0d",
				$time, field, expv, actv);
		endfunction

		function void check_result(logic acc, de_t de, energy_t e, mag_t m);
			flip_outcome_t o;
			if (outcome_q.size() == 0) begin
				errors++;
				$display("%0t: unexpected result word, expected none, actual %0d %0d %0d %0d",
					$time, acc, de, e, m);
				return;
			end
			o = outcome_q.pop_front();
			if (acc !== o.accepted)
				report("accepted", int'(o.accepted), int'(acc));
			if (de !== o.energy_change)
				report("energy_change", int'(o.energy_change), int'(de));
			if (e !== o.total_energy)
				report("total_energy", int'(o.total_energy), int'(e));
			if (m !== o.total_magnetization)
				report("total_magnetization", int'(o.total_magnetization), int'(m));
		endfunction

		function int pending();
			return outcome_q.size();
		endfunction
	endclass

	logic clk;
	logic arst_n;
	bit   idling_on;
	bit   hold_off_request;

	spin_flip_scoreboard sb = new();

	ismu_proposal_if prop_ch ();
	ismu_result_if   res_ch ();
	ismu_cfg_if      cfg_ch ();

	ising_metropolis_spin_update_unit dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.proposal (prop_ch),
		.result   (res_ch),
		.cfg      (cfg_ch)
	);

	initial clk = 1'b0;
	always #1 clk = ~clk;

	always @(posedge clk) begin
		if (arst_n) begin
			if (res_ch.valid && res_ch.ready)
				sb.check_result(res_ch.accepted, res_ch.energy_change,
					res_ch.total_energy, res_ch.total_magnetization);
			if (prop_ch.valid && prop_ch.ready)
				sb.note_proposal(prop_ch.row_index, prop_ch.column_index,
					prop_ch.random_fraction);
			if (cfg_ch.valid && cfg_ch.ready)
				sb.apply_register(cfg_ch.index, cfg_ch.data);
		end
	end

	// result side: random stalls, plus one long hold-off on request
	initial begin : result_sink
		int stall_left;
		stall_left   = 0;
		res_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (stall_left > 0) begin
				res_ch.ready <= 1'b0;
				stall_left--;
			end else if (hold_off_request) begin
				res_ch.ready <= 1'b0;
				stall_left = LONG_HOLD - 1;
				hold_off_request = 1'b0;
			end else if (idling_on && $urandom_range(0, 3) == 0) begin
				res_ch.ready <= 1'b0;
				stall_left = $urandom_range(0, 4);
			end else begin
				res_ch.ready <= 1'b1;
			end
		end
	end

	// called at a falling edge; returns at the falling edge after acceptance
	// with valid still high, the caller lowers it after the last word
	task automatic offer_proposal(input site_index_t row, input site_index_t col,
			input frac_t frac);
		if (idling_on && $urandom_range(0, 3) == 0) begin
			prop_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 5)) @(negedge clk);
		end
		prop_ch.valid           <= 1'b1;
		prop_ch.row_index       <= row;
		prop_ch.column_index    <= col;
		prop_ch.random_fraction <= frac;
		@(posedge clk);
		while (!prop_ch.ready) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic write_register(input cfg_idx_t idx, input frac_t value);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data  <= value;
		@(posedge clk);
		while (!cfg_ch.ready) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic wait_for_results();
		while (sb.pending() != 0) @(negedge clk);
	endtask

	task automatic finish_run();
		wait_for_results();
		repeat (SETTLE_CYCLES) @(negedge clk);
		$display("covered %0d proposals, %0d flips, %0d register writes",
			sb.proposals, sb.flips, sb.reg_writes);
		$display("energy changes -8/-4/0/4/8 seen %0d/%0d/%0d/%0d/%0d times",
			sb.de_hits[0], sb.de_hits[1], sb.de_hits[2], sb.de_hits[3], sb.de_hits[4]);
		if (sb.errors == 0 && sb.pending() == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	endtask

	initial begin : stimulus
		site_index_t row, col, win_r, win_c;
		frac_t       frac, four_val, eight_val;
		int          phase;

		idling_on               = 1'b1;
		hold_off_request        = 1'b0;
		arst_n                  = 1'b0;
		prop_ch.valid           = 1'b0;
		prop_ch.row_index       = '0;
		prop_ch.column_index    = '0;
		prop_ch.random_fraction = '0;
		cfg_ch.valid            = 1'b0;
		cfg_ch.index            = CFG_THRESH_FOUR;
		cfg_ch.data             = '0;
		repeat (10) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// corners with wrap, strict compare at the reset thresholds, all five
		// energy changes
		offer_proposal(7'd0, 7'd0, '0);
		offer_proposal(7'd0, 7'd0, FRAC_MAX);
		offer_proposal(7'd127, 7'd127, FRAC_MAX);
		offer_proposal(7'd127, 7'd127, THRESH_EIGHT_RESET);
		offer_proposal(7'd127, 7'd127, THRESH_EIGHT_RESET - 1);
		offer_proposal(7'd127, 7'd0, THRESH_FOUR_RESET);
		offer_proposal(7'd127, 7'd0, THRESH_FOUR_RESET - 1);
		offer_proposal(7'd0, 7'd127, '0);
		offer_proposal(7'd127, 7'd127, $urandom);
		offer_proposal(7'd127, 7'd127, $urandom);
		offer_proposal(7'd127, 7'd0, $urandom);
		offer_proposal(7'd10, 7'd10, '0);
		offer_proposal(7'd10, 7'd12, '0);
		offer_proposal(7'd10, 7'd11, '0);
		offer_proposal(7'b1010101, 7'b0101010, 32'hAAAA_AAAA);
		offer_proposal(7'b0101010, 7'b1010101, 32'h5555_5555);
		prop_ch.valid <= 1'b0;
		wait_for_results();

		// spare indexes must be ignored; zero thresholds never accept uphill
		write_register(CFG_SPARE_TWO, $urandom);
		write_register(CFG_SPARE_THREE, $urandom);
		write_register(CFG_THRESH_FOUR, '0);
		write_register(CFG_THRESH_EIGHT, '0);
		cfg_ch.valid <= 1'b0;
		offer_proposal(7'd50, 7'd50, '0);
		offer_proposal(7'd10, 7'd13, '0);
		offer_proposal(7'd9, 7'd12, '0);
		prop_ch.valid <= 1'b0;
		wait_for_results();

		write_register(CFG_THRESH_FOUR, FRAC_MAX);
		write_register(CFG_THRESH_EIGHT, FRAC_MAX);
		cfg_ch.valid <= 1'b0;
		offer_proposal(7'd50, 7'd50, FRAC_MAX);
		offer_proposal(7'd50, 7'd50, FRAC_MAX - 1);
		offer_proposal(7'd50, 7'd51, FRAC_MAX - 1);
		prop_ch.valid <= 1'b0;

		for (phase = 0; phase < PHASE_COUNT; phase++) begin
			wait_for_results();
			case (phase)
				0: begin
					four_val  = FRAC_MAX;
					eight_val = FRAC_MAX;
				end
				1: begin
					four_val  = '0;
					eight_val = '0;
				end
				2: begin
					four_val  = THRESH_FOUR_RESET;
					eight_val = THRESH_EIGHT_RESET;
				end
				default: begin
					four_val  = $urandom;
					eight_val = $urandom;
				end
			endcase
			write_register(CFG_THRESH_FOUR, four_val);
			write_register(CFG_THRESH_EIGHT, eight_val);
			cfg_ch.valid <= 1'b0;
			if (phase == PHASE_COUNT - 1)
				idling_on = 1'b0;
			if (phase == 3)
				hold_off_request = 1'b1;
			// the first window straddles the lattice corner
			win_r = (phase == 0) ? 7'd125 : site_index_t'($urandom_range(0, 127));
			win_c = (phase == 0) ? 7'd125 : site_index_t'($urandom_range(0, 127));
			repeat (PHASE_ITEMS) begin
				if ($urandom_range(0, 3) != 0) begin
					row = win_r + site_index_t'($urandom_range(0, 5));
					col = win_c + site_index_t'($urandom_range(0, 5));
				end else begin
					row = site_index_t'($urandom_range(0, 127));
					col = site_index_t'($urandom_range(0, 127));
				end
				case ($urandom_range(0, 4))
					0: frac = $urandom;
					1: frac = sb.thresh_four + frac_t'($urandom_range(0, 4)) - frac_t'(2);
					2: frac = sb.thresh_eight + frac_t'($urandom_range(0, 4)) - frac_t'(2);
					3: frac = frac_t'($urandom_range(0, 255));
					default: frac = ~frac_t'($urandom_range(0, 255));
				endcase
				offer_proposal(row, col, frac);
			end
			prop_ch.valid <= 1'b0;
		end

		finish_run();
	end

	initial begin : watchdog
		#1000000;
		$display("FAILED: results differ");
		$finish;
	end

endmodule

[ising_metropolis_spin_update_unit.f]
+incdir+sv
sv/ismu_pkg.sv
sv/ismu_ifs.sv
sv/ismu_ram.sv
sv/ising_metropolis_spin_update_unit.sv
sv/ismu_checker.sv
verif/ising_metropolis_spin_update_unit_test.sv
